// ----- hdl/ahc_pkg.sv -----
// Shared types and constants for the ADC health conversion block.
// No dependencies; every other file in hdl/ imports this package.
package ahc_pkg;

   // register indexes on the csr port
   localparam logic [2:0] CSR_REF_CAL        = 3'd0;
   localparam logic [2:0] CSR_TS_CAL_LOW     = 3'd1;
   localparam logic [2:0] CSR_TS_CAL_HIGH    = 3'd2;
   localparam logic [2:0] CSR_CAL_REF_MV     = 3'd3;
   localparam logic [2:0] CSR_CAL_TEMP_LOW   = 3'd4;
   localparam logic [2:0] CSR_CAL_TEMP_HIGH  = 3'd5;
   localparam logic [2:0] CSR_DIVIDER_TOP    = 3'd6;
   localparam logic [2:0] CSR_DIVIDER_BOTTOM = 3'd7;

   // pipeline shape
   localparam int FRONT_STAGES = 5;
   localparam int Q_BITS       = 16;

   // operand widths of the three dividers
   localparam int VNUM_W  = 24;
   localparam int BNUM_W  = 53;
   localparam int TNUM_W  = 43;
   localparam int TDEN_W  = 24;

   typedef struct packed {
      logic [11:0] ref_count;
      logic [11:0] sensor_count;
      logic [11:0] batt_count;
   } req_type;

   typedef struct packed {
      logic [15:0]        vdda_mv;
      logic [15:0]        battery_mv;
      logic signed [15:0] temp_centi_c;
      logic               saturated;
      logic               cal_invalid;
   } rsp_type;

   // calibration values and the constants derived from them
   typedef struct packed {
      logic [11:0]        ref_cal;
      logic [11:0]        ts_cal_low;
      logic [VNUM_W-1:0]  vnum;
      logic [15:0]        bot;
      logic [16:0]        dsum;
      logic signed [12:0] dc;
      logic signed [15:0] dt100;
      logic signed [14:0] tl100;
      logic               dcz;
   } cfg_type;

endpackage

// ----- hdl/ahc_csr.sv -----
// Calibration register file plus registered derived constants.
// Depends on ahc_pkg.
module ahc_csr #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   output ahc_pkg::cfg_type        cfg,
   output logic [SAMPLE_BITS+15:0] fsbot
);
   import ahc_pkg::*;

   localparam int FSBW = SAMPLE_BITS + 16;
   localparam logic [SAMPLE_BITS-1:0] FS = '1;

   logic [11:0] ref_cal_ff, ts_cal_low_ff, ts_cal_high_ff, cal_ref_mv_ff;
   logic [7:0]  cal_temp_low_ff, cal_temp_high_ff;
   logic [15:0] divider_top_ff, divider_bottom_ff;

   cfg_type         cfg_in, cfg_ff;
   logic [FSBW-1:0] fsbot_in, fsbot_ff;
   logic [15:0]     bot;
   logic [8:0]      dt9;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_cal_ff        <= 12'd1500;
         ts_cal_low_ff     <= 12'd940;
         ts_cal_high_ff    <= 12'd1210;
         cal_ref_mv_ff     <= 12'd3300;
         cal_temp_low_ff   <= 8'd30;
         cal_temp_high_ff  <= 8'd110;
         divider_top_ff    <= 16'd10000;
         divider_bottom_ff <= 16'd10000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REF_CAL:        ref_cal_ff        <= csr_wdata[11:0];
            CSR_TS_CAL_LOW:     ts_cal_low_ff     <= csr_wdata[11:0];
            CSR_TS_CAL_HIGH:    ts_cal_high_ff    <= csr_wdata[11:0];
            CSR_CAL_REF_MV:     cal_ref_mv_ff     <= csr_wdata[11:0];
            CSR_CAL_TEMP_LOW:   cal_temp_low_ff   <= csr_wdata[7:0];
            CSR_CAL_TEMP_HIGH:  cal_temp_high_ff  <= csr_wdata[7:0];
            CSR_DIVIDER_TOP:    divider_top_ff    <= csr_wdata;
            CSR_DIVIDER_BOTTOM: divider_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // derived constants; a zero lower resistor counts as one
   always_comb begin
      bot              = (divider_bottom_ff == 16'd0) ? 16'd1 : divider_bottom_ff;
      dt9              = {cal_temp_high_ff[7], cal_temp_high_ff}
                       - {cal_temp_low_ff[7], cal_temp_low_ff};
      cfg_in.ref_cal    = ref_cal_ff;
      cfg_in.ts_cal_low = ts_cal_low_ff;
      cfg_in.vnum       = VNUM_W'(cal_ref_mv_ff) * VNUM_W'(ref_cal_ff);
      cfg_in.bot        = bot;
      cfg_in.dsum       = {1'b0, divider_top_ff} + {1'b0, bot};
      cfg_in.dc         = $signed({1'b0, ts_cal_high_ff}) - $signed({1'b0, ts_cal_low_ff});
      cfg_in.dt100      = 16'(16'($signed(dt9)) * 16'sd100);
      cfg_in.tl100      = 15'(15'($signed(cal_temp_low_ff)) * 15'sd100);
      cfg_in.dcz        = (ts_cal_low_ff == ts_cal_high_ff);
      fsbot_in          = FSBW'(FS) * FSBW'(bot);
   end

   always_ff @(posedge clock) begin
      cfg_ff   <= cfg_in;
      fsbot_ff <= fsbot_in;
   end

   assign cfg   = cfg_ff;
   assign fsbot = fsbot_ff;

endmodule

// ----- hdl/ahc_front.sv -----
// Front pipeline: input register and the products that build the dividends
// and divisors of the three conversions. Depends on ahc_pkg.
module ahc_front #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                               clock,
   input  logic [ahc_pkg::FRONT_STAGES-1:0]   ld,
   input  ahc_pkg::req_type                   req_data,
   input  ahc_pkg::cfg_type                   cfg,
   input  logic [SAMPLE_BITS+15:0]            fsbot,
   output logic [11:0]                        rv,
   output logic [ahc_pkg::BNUM_W-1:0]         bnum,
   output logic [SAMPLE_BITS+27:0]            bden,
   output logic [ahc_pkg::TNUM_W-1:0]         tnum,
   output logic [ahc_pkg::TDEN_W-1:0]         tden,
   output logic                               rvz,
   output logic                               tneg
);
   import ahc_pkg::*;

   localparam int FSBW  = SAMPLE_BITS + 16;
   localparam int DENBW = FSBW + 12;

   req_type in_ff;

   // stage 1
   logic               rvz1_ff;
   logic [11:0]        rv1_ff;
   logic [35:0]        rbv1_ff;
   logic [DENBW-1:0]   denb1_ff;
   logic [23:0]        a1_ff, lb1_ff;
   logic signed [24:0] bd1_ff;
   logic [11:0]        b1;
   // stage 2
   logic               rvz2_ff;
   logic [11:0]        rv2_ff;
   logic [BNUM_W-1:0]  bnum2_ff;
   logic [DENBW-1:0]   denb2_ff;
   logic signed [25:0] tdiff2_ff;
   logic signed [39:0] tlden2_ff;
   logic signed [24:0] bd2_ff;
   // stage 3
   logic               rvz3_ff;
   logic [11:0]        rv3_ff;
   logic [BNUM_W-1:0]  bnum3_ff;
   logic [DENBW-1:0]   denb3_ff;
   logic signed [TNUM_W-1:0] tnum3_ff;
   logic signed [24:0] bd3_ff;
   // stage 4
   logic               rvz4_ff, tneg4_ff;
   logic [11:0]        rv4_ff;
   logic [BNUM_W-1:0]  bnum4_ff;
   logic [DENBW-1:0]   denb4_ff;
   logic [TNUM_W-1:0]  tnum4_ff;
   logic [TDEN_W-1:0]  tden4_ff;

   // zero reference reading: compensation ratio taken as 0/1
   assign b1 = (in_ff.ref_count == 12'd0) ? 12'd1 : in_ff.ref_count;

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         in_ff <= req_data;
      end
      // products of raw counts with calibration values
      if (ld[1]) begin
         rvz1_ff  <= (in_ff.ref_count == 12'd0);
         rv1_ff   <= in_ff.ref_count;
         rbv1_ff  <= 36'(in_ff.batt_count) * 36'(cfg.vnum);
         denb1_ff <= DENBW'(in_ff.ref_count) * DENBW'(fsbot);
         a1_ff    <= (in_ff.ref_count == 12'd0) ? 24'd0
                   : 24'(in_ff.sensor_count) * 24'(cfg.ref_cal);
         lb1_ff   <= 24'(cfg.ts_cal_low) * 24'(b1);
         bd1_ff   <= 25'($signed({1'b0, b1})) * 25'(cfg.dc);
      end
      // battery dividend, temperature offset terms
      if (ld[2]) begin
         rvz2_ff   <= rvz1_ff;
         rv2_ff    <= rv1_ff;
         bnum2_ff  <= BNUM_W'(rbv1_ff) * BNUM_W'(cfg.dsum);
         denb2_ff  <= denb1_ff;
         tdiff2_ff <= $signed(26'(a1_ff)) - $signed(26'(lb1_ff));
         tlden2_ff <= 40'(bd1_ff) * 40'(cfg.tl100);
         bd2_ff    <= bd1_ff;
      end
      // temperature dividend
      if (ld[3]) begin
         rvz3_ff  <= rvz2_ff;
         rv3_ff   <= rv2_ff;
         bnum3_ff <= bnum2_ff;
         denb3_ff <= denb2_ff;
         tnum3_ff <= TNUM_W'(tdiff2_ff) * TNUM_W'(cfg.dt100) + TNUM_W'(tlden2_ff);
         bd3_ff   <= bd2_ff;
      end
      // sign and magnitude for the unsigned divider
      if (ld[4]) begin
         rvz4_ff  <= rvz3_ff;
         rv4_ff   <= rv3_ff;
         bnum4_ff <= bnum3_ff;
         denb4_ff <= denb3_ff;
         tneg4_ff <= tnum3_ff[TNUM_W-1] ^ bd3_ff[24];
         tnum4_ff <= tnum3_ff[TNUM_W-1] ? TNUM_W'(-tnum3_ff) : TNUM_W'(tnum3_ff);
         tden4_ff <= bd3_ff[24] ? TDEN_W'(-bd3_ff) : TDEN_W'(bd3_ff);
      end
   end

   assign rv   = rv4_ff;
   assign bnum = bnum4_ff;
   assign bden = denb4_ff;
   assign tnum = tnum4_ff;
   assign tden = tden4_ff;
   assign rvz  = rvz4_ff;
   assign tneg = tneg4_ff;

endmodule

// ----- hdl/ahc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit. Depends on ahc_pkg.
module ahc_div #(
   parameter int NW = 24,
   parameter int DW = 12,
   parameter int QW = 16,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic [QW:0]   ld,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side,
   output logic [QW-1:0] q,
   output logic          ovf,
   output logic [SW-1:0] side_out
);
   import ahc_pkg::*;

   localparam int W = (NW > DW + QW) ? NW : DW + QW;

   logic [W-1:0]  rem_ff  [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [QW-1:0] q_ff    [QW+1];
   logic          ovf_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];

   logic [W-1:0]  rem_in [QW+1];
   logic [QW-1:0] q_in   [QW+1];
   logic [W-1:0]  trial  [QW+1];
   logic          ovf0;

   // stage 0 checks for overflow; later stages each resolve one bit
   always_comb begin
      ovf0      = ({1'b0, W'(num)} >= ({1'b0, W'(den)} << QW));
      rem_in[0] = ovf0 ? '0 : W'(num);
      q_in[0]   = '0;
      trial[0]  = '0;
      for (int j = 1; j <= QW; j++) begin
         trial[j]  = W'(den_ff[j-1]) << (QW - j);
         rem_in[j] = rem_ff[j-1];
         q_in[j]   = q_ff[j-1];
         if (rem_ff[j-1] >= trial[j]) begin
            rem_in[j]        = rem_ff[j-1] - trial[j];
            q_in[j][QW - j]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         rem_ff[0]  <= rem_in[0];
         den_ff[0]  <= den;
         q_ff[0]    <= q_in[0];
         ovf_ff[0]  <= ovf0;
         side_ff[0] <= side;
      end
      for (int j = 1; j <= QW; j++) begin
         if (ld[j]) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_ff[j-1];
            q_ff[j]    <= q_in[j];
            ovf_ff[j]  <= ovf_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign q        = q_ff[QW];
   assign ovf      = ovf_ff[QW];
   assign side_out = side_ff[QW];

endmodule

// ----- hdl/adc_health_conversion.sv -----
// ADC health conversion top level: supply, battery and temperature from one
// ADC snapshot. Depends on ahc_pkg, ahc_csr, ahc_front and ahc_div.
//
// Usage:
//   req_* carries one snapshot (reference, sensor, battery counts) a beat;
//   a beat moves when req_valid is high and req_stall is low.
//   rsp_* returns one result beat per snapshot, in order, under the same
//   valid/stall rule; rsp_valid is a register output.
//   csr_* writes the calibration registers (index 0..7, data in the low
//   bits); csr_ready is always high. Write only while no beat is in flight.
// Timing:
//   23 register stages: 5 front stages of multipliers, 17 divider stages
//   (overflow check plus one quotient bit per stage for each of the three
//   dividers) and the output register, which drives rsp_valid.
//   Throughput is one snapshot per cycle while rsp_stall is low.
// Reset and stall:
//   Reset empties the pipeline and loads the factory calibration values.
//   A stalled result holds; each stage keeps moving while a later stage
//   has room, so bubbles collapse and req_stall rises only when all 23
//   stages are full.
module adc_health_conversion #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ahc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ahc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);
   import ahc_pkg::*;

   localparam int FSBW   = SAMPLE_BITS + 16;
   localparam int DENBW  = FSBW + 12;
   localparam int DIV0   = FRONT_STAGES;
   localparam int OUT_ST = FRONT_STAGES + Q_BITS + 1;
   localparam int L      = OUT_ST + 1;

   cfg_type           cfg;
   logic [FSBW-1:0]   fsbot;
   logic [L-1:0]      valid_ff;
   logic [L:0]        ready;

   logic [11:0]       rv;
   logic [BNUM_W-1:0] bnum;
   logic [DENBW-1:0]  bden;
   logic [TNUM_W-1:0] tnum;
   logic [TDEN_W-1:0] tden;
   logic              rvz, tneg;

   logic [Q_BITS-1:0] qv, qb, qt;
   logic              ovfv, ovfb, ovft;
   logic              rvz_v, rvz_b, tneg_t;

   rsp_type           rsp_in, rsp_ff;
   logic              sat_v, sat_b, sat_t;

   ahc_csr #(.SAMPLE_BITS(SAMPLE_BITS)) u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .cfg, .fsbot
   );

   // a stage may load when it is empty or the next one loads
   always_comb begin
      ready[L] = !rsp_stall;
      for (int i = L - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   assign req_stall = !ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < L; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   ahc_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .ld(ready[FRONT_STAGES-1:0]), .req_data, .cfg, .fsbot,
      .rv, .bnum, .bden, .tnum, .tden, .rvz, .tneg
   );

   // supply: cal_ref_mv * reference calibration count / reference reading
   ahc_div #(.NW(VNUM_W), .DW(12), .QW(Q_BITS), .SW(1)) u_div_vdda (
      .clock, .ld(ready[DIV0+Q_BITS:DIV0]), .num(cfg.vnum), .den(rv),
      .side(rvz), .q(qv), .ovf(ovfv), .side_out(rvz_v)
   );

   // battery
   ahc_div #(.NW(BNUM_W), .DW(DENBW), .QW(Q_BITS), .SW(1)) u_div_batt (
      .clock, .ld(ready[DIV0+Q_BITS:DIV0]), .num(bnum), .den(bden),
      .side(rvz), .q(qb), .ovf(ovfb), .side_out(rvz_b)
   );

   // temperature magnitude
   ahc_div #(.NW(TNUM_W), .DW(TDEN_W), .QW(Q_BITS), .SW(1)) u_div_temp (
      .clock, .ld(ready[DIV0+Q_BITS:DIV0]), .num(tnum), .den(tden),
      .side(tneg), .q(qt), .ovf(ovft), .side_out(tneg_t)
   );

   // saturation and special cases
   always_comb begin
      sat_v = !rvz_v && ovfv;
      sat_b = !rvz_b && ovfb;
      sat_t = 1'b0;
      rsp_in.vdda_mv    = rvz_v ? 16'd0 : (ovfv ? 16'hFFFF : qv);
      rsp_in.battery_mv = rvz_b ? 16'd0 : (ovfb ? 16'hFFFF : qb);
      if (cfg.dcz) begin
         rsp_in.temp_centi_c = 16'sd0;
      end else if (!tneg_t) begin
         if (ovft || qt > 16'd32767) begin
            rsp_in.temp_centi_c = 16'sh7FFF;
            sat_t = 1'b1;
         end else begin
            rsp_in.temp_centi_c = $signed(qt);
         end
      end else begin
         if (ovft || qt > 16'd32768) begin
            rsp_in.temp_centi_c = 16'sh8000;
            sat_t = 1'b1;
         end else begin
            rsp_in.temp_centi_c = $signed(16'(-qt));
         end
      end
      rsp_in.saturated   = sat_v || sat_b || sat_t;
      rsp_in.cal_invalid = rvz_v || cfg.dcz;
   end

   always_ff @(posedge clock) begin
      if (ready[OUT_ST]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[OUT_ST];
   assign rsp_data  = rsp_ff;

endmodule
